// File: hw/rtl/vac_pkg.sv
// ----------------------------------------------------------------------------
// vac_pkg
// Shared types and constants of the voice allocator with choke groups.
// ----------------------------------------------------------------------------
package vac_pkg;

    localparam int VOICES     = 16;
    localparam int PADS       = 16;
    localparam int VIW        = $clog2(VOICES);
    localparam int VPOW       = 1 << VIW;
    localparam int LEVELS     = VIW;
    localparam int LVW        = $clog2(LEVELS + 1);
    localparam int MASK_BITS  = (VOICES < 16) ? VOICES : 16;
    localparam int FIFO_DEPTH = 2;
    localparam int QAW        = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int QCW        = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] FUNC_NOTE_ON   = 2'd0;
    localparam logic [1:0] FUNC_FINISH    = 2'd1;
    localparam logic [1:0] FUNC_RESET_ALL = 2'd2;
    localparam logic [1:0] FUNC_UNUSED    = 2'd3;

    typedef logic [VIW-1:0]    voice_idx_t;
    typedef logic [VOICES-1:0] voice_vec_t;
    typedef logic [31:0]       stamp_t;

    typedef enum logic [1:0] {
        CMD_NOTE,
        CMD_FREE,
        CMD_CLEAR,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [3:0]  group;
        logic [3:0]  voice;
    } cmd_t;

endpackage

// File: hw/rtl/vac_front.sv
// ----------------------------------------------------------------------------
// vac_front
// Holds the mute register and turns each input transaction into a command.
// ----------------------------------------------------------------------------
module vac_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write_en,
    input  logic [15:0]   cfg_write_data,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    func,
    input  logic [3:0]    pad,
    input  logic [3:0]    choke_group,
    input  logic          pad_has_sample,
    input  logic [3:0]    voice_index,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output vac_pkg::cmd_t cmd
);
    import vac_pkg::*;

    logic [15:0] mute_mask_reg;
    logic        pad_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mute_mask_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            mute_mask_reg <= cfg_write_data;
        end
    end

    always_comb
    begin
        pad_ok    = (32'(pad) < PADS) && pad_has_sample && !mute_mask_reg[pad];
        cmd.group = choke_group;
        cmd.voice = voice_index;
        unique case (func)
            FUNC_NOTE_ON:   cmd.kind = pad_ok ? CMD_NOTE : CMD_NOP;
            FUNC_FINISH:    cmd.kind = CMD_FREE;
            FUNC_RESET_ALL: cmd.kind = CMD_CLEAR;
            default:        cmd.kind = CMD_NOP;
        endcase
    end

    assign cmd_valid = in_valid;
    assign in_ready  = cmd_ready;

endmodule

// File: hw/rtl/vac_queue.sv
// ----------------------------------------------------------------------------
// vac_queue
// Short command queue between the front and the back of the allocator.
// ----------------------------------------------------------------------------
module vac_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  vac_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output vac_pkg::cmd_t pop_cmd
);
    import vac_pkg::*;

    cmd_t           entry_reg [FIFO_DEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QCW-1:0] count_reg;
    logic           push;
    logic           pop;

    assign push_ready = (count_reg != QCW'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QAW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QAW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: hw/rtl/vac_back.sv
// ----------------------------------------------------------------------------
// vac_back
// Voice state, choking, free voice search, oldest voice search and result.
// ----------------------------------------------------------------------------
module vac_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  vac_pkg::cmd_t cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          accepted,
    output logic [3:0]    assigned_voice,
    output logic          was_stolen,
    output logic [15:0]   choke_mask,
    output logic [15:0]   active_mask
);
    import vac_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } state_t;

    function automatic logic [15:0] low_mask(voice_vec_t v);
        logic [15:0] m;
        m = '0;
        for (int i = 0; i < MASK_BITS; i++)
        begin
            m[i] = v[i];
        end
        return m;
    endfunction

    state_t         state_reg, state_next;
    voice_vec_t     active_reg, active_next;
    voice_vec_t     choking_reg, choking_next;
    logic [3:0]     group_reg [VOICES];
    logic [3:0]     group_next [VOICES];
    stamp_t         stamp_reg [VOICES];
    stamp_t         stamp_next [VOICES];
    stamp_t         counter_reg, counter_next;
    logic [3:0]     hold_group_reg, hold_group_next;
    logic [LVW-1:0] level_reg, level_next;
    voice_idx_t     cand_idx_reg [VPOW];
    voice_idx_t     cand_idx_next [VPOW];
    stamp_t         cand_stamp_reg [VPOW];
    stamp_t         cand_stamp_next [VPOW];
    logic           cand_vld_reg [VPOW];
    logic           cand_vld_next [VPOW];
    logic           out_valid_reg, out_valid_next;
    logic           accepted_reg, accepted_next;
    logic [3:0]     assigned_reg, assigned_next;
    logic           stolen_reg, stolen_next;
    logic [15:0]    choke_mask_reg, choke_mask_next;
    logic [15:0]    active_mask_reg, active_mask_next;

    voice_vec_t     choke_hit;
    logic           free_found;
    voice_idx_t     free_idx;
    logic           pop;
    logic           do_output;
    logic           do_commit;
    voice_idx_t     commit_idx;
    logic           commit_stolen;
    logic [3:0]     commit_group;
    voice_idx_t     vidx;
    logic           vidx_ok;
    voice_idx_t     red_idx [VPOW/2];
    stamp_t         red_stamp [VPOW/2];
    logic           red_vld [VPOW/2];
    logic           take_odd;

    assign cmd_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign pop       = cmd_valid && cmd_ready;
    assign vidx      = VIW'(cmd.voice);
    assign vidx_ok   = (32'(cmd.voice) < VOICES);

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = VIW'(i);
            end
        end
        for (int i = 0; i < VOICES; i++)
        begin
            choke_hit[i] = active_reg[i] && (group_reg[i] == cmd.group)
                           && !choking_reg[i] && (cmd.group != '0);
        end
    end

    always_comb
    begin
        for (int i = 0; i < VPOW / 2; i++)
        begin
            take_odd = cand_vld_reg[2*i+1]
                       && (!cand_vld_reg[2*i] || (cand_stamp_reg[2*i+1] < cand_stamp_reg[2*i]));
            red_idx[i]   = take_odd ? cand_idx_reg[2*i+1] : cand_idx_reg[2*i];
            red_stamp[i] = take_odd ? cand_stamp_reg[2*i+1] : cand_stamp_reg[2*i];
            red_vld[i]   = cand_vld_reg[2*i] || cand_vld_reg[2*i+1];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        active_next      = active_reg;
        choking_next     = choking_reg;
        group_next       = group_reg;
        stamp_next       = stamp_reg;
        counter_next     = counter_reg;
        hold_group_next  = hold_group_reg;
        level_next       = level_reg;
        cand_idx_next    = cand_idx_reg;
        cand_stamp_next  = cand_stamp_reg;
        cand_vld_next    = cand_vld_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        accepted_next    = accepted_reg;
        assigned_next    = assigned_reg;
        stolen_next      = stolen_reg;
        choke_mask_next  = choke_mask_reg;
        active_mask_next = active_mask_reg;
        do_output        = 1'b0;
        do_commit        = 1'b0;
        commit_idx       = free_idx;
        commit_stolen    = 1'b0;
        commit_group     = cmd.group;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    accepted_next   = 1'b0;
                    assigned_next   = '0;
                    stolen_next     = 1'b0;
                    choke_mask_next = '0;
                    unique case (cmd.kind)
                        CMD_NOTE:
                        begin
                            choking_next    = choking_reg | choke_hit;
                            choke_mask_next = low_mask(choke_hit);
                            if (free_found)
                            begin
                                do_commit = 1'b1;
                                do_output = 1'b1;
                            end
                            else
                            begin
                                hold_group_next = cmd.group;
                                level_next      = '0;
                                state_next      = S_SEARCH;
                                for (int i = 0; i < VPOW; i++)
                                begin
                                    cand_idx_next[i]   = VIW'(i);
                                    cand_vld_next[i]   = (i < VOICES);
                                    cand_stamp_next[i] = stamp_reg[(i < VOICES) ? i : 0];
                                end
                            end
                        end
                        CMD_FREE:
                        begin
                            if (vidx_ok)
                            begin
                                active_next[vidx]  = 1'b0;
                                choking_next[vidx] = 1'b0;
                            end
                            do_output = 1'b1;
                        end
                        CMD_CLEAR:
                        begin
                            active_next  = '0;
                            choking_next = '0;
                            do_output    = 1'b1;
                        end
                        default:
                        begin
                            do_output = 1'b1;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                for (int i = 0; i < VPOW / 2; i++)
                begin
                    cand_idx_next[i]   = red_idx[i];
                    cand_stamp_next[i] = red_stamp[i];
                    cand_vld_next[i]   = red_vld[i];
                end
                level_next = level_reg + 1'b1;
                if (level_reg == LVW'(LEVELS - 1))
                begin
                    do_commit     = 1'b1;
                    do_output     = 1'b1;
                    commit_idx    = red_idx[0];
                    commit_stolen = 1'b1;
                    commit_group  = hold_group_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_commit)
        begin
            counter_next               = counter_reg + 1'b1;
            active_next[commit_idx]    = 1'b1;
            choking_next[commit_idx]   = 1'b0;
            group_next[commit_idx]     = commit_group;
            stamp_next[commit_idx]     = counter_reg + 1'b1;
            accepted_next              = 1'b1;
            assigned_next              = 4'(commit_idx);
            stolen_next                = commit_stolen;
        end

        if (do_output)
        begin
            out_valid_next   = 1'b1;
            active_mask_next = low_mask(active_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            active_reg      <= '0;
            choking_reg     <= '0;
            counter_reg     <= '0;
            hold_group_reg  <= '0;
            level_reg       <= '0;
            out_valid_reg   <= 1'b0;
            accepted_reg    <= 1'b0;
            assigned_reg    <= '0;
            stolen_reg      <= 1'b0;
            choke_mask_reg  <= '0;
            active_mask_reg <= '0;
            for (int i = 0; i < VOICES; i++)
            begin
                group_reg[i] <= '0;
                stamp_reg[i] <= '0;
            end
            for (int i = 0; i < VPOW; i++)
            begin
                cand_idx_reg[i]   <= '0;
                cand_stamp_reg[i] <= '0;
                cand_vld_reg[i]   <= 1'b0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            active_reg      <= active_next;
            choking_reg     <= choking_next;
            counter_reg     <= counter_next;
            hold_group_reg  <= hold_group_next;
            level_reg       <= level_next;
            out_valid_reg   <= out_valid_next;
            accepted_reg    <= accepted_next;
            assigned_reg    <= assigned_next;
            stolen_reg      <= stolen_next;
            choke_mask_reg  <= choke_mask_next;
            active_mask_reg <= active_mask_next;
            group_reg       <= group_next;
            stamp_reg       <= stamp_next;
            cand_idx_reg    <= cand_idx_next;
            cand_stamp_reg  <= cand_stamp_next;
            cand_vld_reg    <= cand_vld_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign accepted       = accepted_reg;
    assign assigned_voice = assigned_reg;
    assign was_stolen     = stolen_reg;
    assign choke_mask     = choke_mask_reg;
    assign active_mask    = active_mask_reg;

    // A voice is only stolen when every voice is busy.
    a_search_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |-> &active_reg)
        else $error("oldest voice search started with a free voice");

    a_search_output_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |-> !out_valid_reg)
        else $error("result pending while a search is running");

    a_reject_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !accepted_reg |->
            assigned_reg == '0 && !stolen_reg && choke_mask_reg == '0)
        else $error("result fields set for a transaction without assignment");

    a_stamp_moves_on_assign: assert property (@(posedge clk) disable iff (!rst_n)
        counter_reg != $past(counter_reg) |-> out_valid_reg && accepted_reg)
        else $error("stamp counter advanced without a voice assignment");

endmodule

// File: hw/rtl/voice_allocator_choke_groups.sv
// ----------------------------------------------------------------------------
// voice_allocator_choke_groups
// Voice allocator with choke groups and oldest voice stealing.
// ----------------------------------------------------------------------------
// Every input transaction gives exactly one result transaction. The front
// classifies a transaction in the cycle it is accepted and places it in a
// two-entry command queue, so input is taken while a result still waits.
// The back executes one command at a time: a voice-finished, reset, rejected
// or ignored event and a note-on that finds a free voice are finished in the
// idle state, while a note-on that must steal first runs the registered
// pairwise minimum tree over the voice start stamps, one tree level per
// cycle, and then commits the oldest voice.
module voice_allocator_choke_groups (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [3:0]  pad,
    input  logic [3:0]  choke_group,
    input  logic        pad_has_sample,
    input  logic [3:0]  voice_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic [3:0]  assigned_voice,
    output logic        was_stolen,
    output logic [15:0] choke_mask,
    output logic [15:0] active_mask
);
    import vac_pkg::*;

    cmd_t front_cmd;
    cmd_t back_cmd;
    logic front_valid;
    logic front_ready;
    logic back_valid;
    logic back_ready;

    vac_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .pad            (pad),
        .choke_group    (choke_group),
        .pad_has_sample (pad_has_sample),
        .voice_index    (voice_index),
        .cmd_valid      (front_valid),
        .cmd_ready      (front_ready),
        .cmd            (front_cmd)
    );

    vac_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_cmd    (back_cmd)
    );

    vac_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (back_valid),
        .cmd_ready      (back_ready),
        .cmd            (back_cmd),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .accepted       (accepted),
        .assigned_voice (assigned_voice),
        .was_stolen     (was_stolen),
        .choke_mask     (choke_mask),
        .active_mask    (active_mask)
    );

endmodule
